@@ hdl/prle_pkg.sv @@
`timescale 1ns / 1ps
package prle_pkg;

   localparam int unsigned PIXEL_WIDTH = 32;
   localparam int unsigned COUNT_WIDTH = 8;
   localparam int unsigned MODE_WIDTH  = 2;
   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [COUNT_WIDTH-1:0] RUN_CAP = 8'd255;

   localparam logic [MODE_WIDTH-1:0] MODE_ALPHA = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_RGB   = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_RGBA  = 2'd2;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] run_count;
      logic [PIXEL_WIDTH-1:0] run_pixel;
      logic                   item_last;
      logic                   frame_end;
   } record_type;

   typedef struct packed {
      logic       first_valid;
      logic       second_valid;
      record_type first;
      record_type second;
   } push_type;

   function automatic logic [PIXEL_WIDTH-1:0] mode_mask(input logic [MODE_WIDTH-1:0] mode);
      logic [PIXEL_WIDTH-1:0] mask;
      case (mode)
         MODE_ALPHA: mask = 32'h0000_00ff;
         MODE_RGB:   mask = 32'h00ff_ffff;
         MODE_RGBA:  mask = 32'hffff_ffff;
         default:    mask = 32'hffff_ffff;
      endcase
      return mask;
   endfunction

endpackage

@@ hdl/prle_core.sv @@
`timescale 1ns / 1ps
module prle_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic [prle_pkg::PIXEL_WIDTH-1:0]  pixel_value,
   input  logic                              frame_last,
   input  logic                              csr_write,
   input  logic [prle_pkg::MODE_WIDTH-1:0]   csr_mode,
   output prle_pkg::push_type                push
);
   import prle_pkg::*;

   logic [MODE_WIDTH-1:0]  mode_ff;
   logic [PIXEL_WIDTH-1:0] held_ff, held_in, pix;
   logic [COUNT_WIDTH-1:0] len_ff, len_in;
   logic                   open_ff, open_in;
   logic                   close_run;

   always_comb begin
      pix       = pixel_value & mode_mask(mode_ff);
      close_run = open_ff && ((held_ff != pix) || (len_ff == RUN_CAP));
      held_in   = held_ff;
      len_in    = len_ff;
      open_in   = open_ff;
      if (!open_ff || close_run) begin
         held_in = pix;
         len_in  = COUNT_WIDTH'(1);
         open_in = 1'b1;
      end else begin
         len_in = len_ff + COUNT_WIDTH'(1);
      end

      push.first_valid          = 1'b0;
      push.second_valid         = 1'b0;
      push.first.run_count      = len_ff;
      push.first.run_pixel      = held_ff;
      push.first.item_last      = !frame_last;
      push.first.frame_end      = 1'b0;
      push.second.run_count     = len_in;
      push.second.run_pixel     = held_in;
      push.second.item_last     = 1'b1;
      push.second.frame_end     = 1'b1;

      if (accept) begin
         if (close_run) begin
            push.first_valid  = 1'b1;
            push.second_valid = frame_last;
         end else if (frame_last) begin
            push.first_valid = 1'b1;
            push.first       = push.second;
         end
      end

      if (frame_last) begin
         held_in = '0;
         len_in  = '0;
         open_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ALPHA;
         held_ff <= '0;
         len_ff  <= '0;
         open_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            mode_ff <= csr_mode;
         end
         if (accept) begin
            held_ff <= held_in;
            len_ff  <= len_in;
            open_ff <= open_in;
         end
      end
   end

endmodule

@@ hdl/prle_queue.sv @@
`timescale 1ns / 1ps
module prle_queue #(
   parameter int unsigned DEPTH = prle_pkg::QUEUE_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  prle_pkg::push_type           push,
   input  logic                         pop,
   output prle_pkg::record_type         head,
   output logic                         not_empty,
   output logic [$clog2(DEPTH+1)-1:0]   fill
);
   import prle_pkg::*;

   localparam int unsigned PTR_WIDTH  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned FILL_WIDTH = $clog2(DEPTH+1);

   record_type           entry_ff [DEPTH];
   logic [PTR_WIDTH-1:0] wr_ff, wr_in, wr_next, rd_ff, rd_in;
   logic [FILL_WIDTH-1:0] fill_ff, fill_in;
   logic [1:0]           push_count;

   function automatic logic [PTR_WIDTH-1:0] bump(input logic [PTR_WIDTH-1:0] ptr);
      return (ptr == PTR_WIDTH'(DEPTH-1)) ? '0 : ptr + PTR_WIDTH'(1);
   endfunction

   always_comb begin
      wr_next    = bump(wr_ff);
      push_count = 2'(push.first_valid) + 2'(push.second_valid);
      wr_in      = wr_ff;
      if (push.second_valid) begin
         wr_in = bump(wr_next);
      end else if (push.first_valid) begin
         wr_in = wr_next;
      end
      rd_in   = pop ? bump(rd_ff) : rd_ff;
      fill_in = fill_ff + FILL_WIDTH'(push_count) - FILL_WIDTH'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         entry_ff[wr_ff] <= push.first;
      end
      if (push.second_valid) begin
         entry_ff[wr_next] <= push.second;
      end
   end

   assign head      = entry_ff[rd_ff];
   assign not_empty = (fill_ff != '0);
   assign fill      = fill_ff;

endmodule

@@ hdl/pixel_run_length_encoder.sv @@
`timescale 1ns / 1ps
// a run's record is queued when the pixel word closing the run is accepted
// throughput: one pixel word per cycle while records drain freely; req_stall rises only
//    under record back-pressure, once three or more records wait in the four-entry queue
// reset: synchronous, clears the open run, the record queue and the mode (alpha)
module pixel_run_length_encoder #(
   parameter int unsigned QUEUE_DEPTH = prle_pkg::QUEUE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [prle_pkg::PIXEL_WIDTH-1:0]  req_pixel_value,
   input  logic                              req_frame_last,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [prle_pkg::COUNT_WIDTH-1:0]  rsp_run_count,
   output logic [prle_pkg::PIXEL_WIDTH-1:0]  rsp_run_pixel,
   output logic                              rsp_item_last,
   output logic                              rsp_frame_end,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [prle_pkg::MODE_WIDTH-1:0]   csr_pixel_mode
);
   import prle_pkg::*;

   localparam int unsigned FILL_WIDTH = $clog2(QUEUE_DEPTH+1);

   push_type              push;
   record_type            head;
   logic                  accept, pop, not_empty;
   logic [FILL_WIDTH-1:0] fill;

   assign csr_ready = 1'b1;
   assign req_stall = (fill > FILL_WIDTH'(QUEUE_DEPTH-2));
   assign accept    = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;

   prle_core u_core (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .pixel_value (req_pixel_value),
      .frame_last  (req_frame_last),
      .csr_write   (csr_valid && csr_ready),
      .csr_mode    (csr_pixel_mode),
      .push        (push)
   );

   prle_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty),
      .fill      (fill)
   );

   assign rsp_valid     = not_empty;
   assign rsp_run_count = head.run_count;
   assign rsp_run_pixel = head.run_pixel;
   assign rsp_item_last = head.item_last;
   assign rsp_frame_end = head.frame_end;

   // queue never overruns
   assert property (@(posedge clock) disable iff (reset)
      fill <= FILL_WIDTH'(QUEUE_DEPTH))
      else $error("record queue overrun");

   // frame end record always closes its word
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_end) |-> rsp_item_last)
      else $error("frame end without item last");

   // no empty run is ever emitted
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_run_count != '0))
      else $error("zero length run");

   // records are pushed only for an accepted word
   assert property (@(posedge clock) disable iff (reset)
      (push.first_valid || push.second_valid) |-> accept)
      else $error("record pushed without word");

endmodule
